[design/rc4_pkg.sv]
// rc4_pkg: shared constants for the rc4 keystream cipher
// box geometry, default key store depth and request codes
// no dependencies

package rc4_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned BOX_SIZE    = 256;
	localparam int unsigned KEY_MAX_DEF = 64;

	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

[design/rc4_stream_cipher.sv]
// rc4_stream_cipher: rc4 key loader, key schedule and keystream generator
// single-port permutation box and key store driven by one sequencer
// depends on rc4_pkg
//
// channel | signals                                    | direction
// --------+--------------------------------------------+----------
// input   | in_valid, in_ready, req_type, byte_value,  | in
//         | key_last                                   |
// output  | out_valid, out_ready, out_byte             | out
//
// key byte: stored in idle with no box access; data byte: paced by the single box port
// (three reads and two writes per byte, one access per cycle)
// last key byte: box refill, then read i, read j, write i and write j steps per box entry
// after reset the box refill runs over all box entries with in_ready low
// a data byte waits in its last step while the output register is still full

module rc4_stream_cipher #(
	parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  rc4_pkg::byte_t      byte_value,
	input  logic                key_last,
	output logic                out_valid,
	input  logic                out_ready,
	output rc4_pkg::byte_t      out_byte
);

	import rc4_pkg::*;

	localparam int unsigned CW = $clog2(KEY_MAX + 1);
	localparam int unsigned KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam byte_t BOX_LAST = byte_t'(BOX_SIZE - 1);

	typedef enum logic [3:0] {
		S_FILL,
		S_IDLE,
		S_K_RD_I,
		S_K_RD_J,
		S_K_WR_I,
		S_K_WR_J,
		S_D_RD_I,
		S_D_RD_J,
		S_D_WR_I,
		S_D_WR_J,
		S_D_RD_T,
		S_D_OUT
	} state_t;

	state_t          state_q;
	logic            sched_q;
	byte_t           n_q;
	byte_t           j_q;
	logic [KW-1:0]   pos_q;
	logic [CW-1:0]   key_count_q;
	byte_t           gi_q;
	byte_t           gj_q;
	byte_t           si_q;
	byte_t           sj_q;
	byte_t           data_q;
	byte_t           out_byte_q;
	logic            out_valid_q;

	byte_t           box_mem [0:BOX_SIZE-1];
	byte_t           box_rd_q;
	logic            box_we;
	logic            box_re;
	byte_t           box_addr;
	byte_t           box_wdata;

	byte_t           key_mem [0:KEY_MAX-1];
	byte_t           key_rd_q;
	logic            key_we;
	byte_t           kb;
	logic [CW-1:0]   pos_inc;

	logic            in_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	assign key_we  = in_fire && (req_type == REQ_KEY) && (key_count_q < CW'(KEY_MAX));
	assign kb      = (key_count_q == '0) ? '0 : key_rd_q;
	assign pos_inc = CW'(pos_q) + CW'(1);

	// box port control
	always_comb begin
		box_we    = 1'b0;
		box_re    = 1'b0;
		box_addr  = n_q;
		box_wdata = n_q;
		unique case (state_q)
			S_FILL: begin
				box_we    = 1'b1;
				box_addr  = n_q;
				box_wdata = n_q;
			end
			S_K_RD_I: begin
				box_re   = 1'b1;
				box_addr = n_q;
			end
			S_K_RD_J: begin
				box_re   = 1'b1;
				box_addr = j_q + box_rd_q + kb;
			end
			S_K_WR_I: begin
				box_we    = 1'b1;
				box_addr  = n_q;
				box_wdata = box_rd_q;
			end
			S_K_WR_J: begin
				box_we    = 1'b1;
				box_addr  = j_q;
				box_wdata = si_q;
			end
			S_D_RD_I: begin
				box_re   = 1'b1;
				box_addr = gi_q;
			end
			S_D_RD_J: begin
				box_re   = 1'b1;
				box_addr = gj_q + box_rd_q;
			end
			S_D_WR_I: begin
				box_we    = 1'b1;
				box_addr  = gi_q;
				box_wdata = box_rd_q;
			end
			S_D_WR_J: begin
				box_we    = 1'b1;
				box_addr  = gj_q;
				box_wdata = si_q;
			end
			S_D_RD_T: begin
				box_re   = 1'b1;
				box_addr = si_q + sj_q;
			end
			S_IDLE, S_D_OUT: begin
				box_we = 1'b0;
				box_re = 1'b0;
			end
			default: begin
				box_we = 1'b0;
				box_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (box_we) begin
			box_mem[box_addr] <= box_wdata;
		end else if (box_re) begin
			box_rd_q <= box_mem[box_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_count_q[KW-1:0]] <= byte_value;
		end
		key_rd_q <= key_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			sched_q     <= 1'b0;
			n_q         <= '0;
			j_q         <= '0;
			pos_q       <= '0;
			key_count_q <= '0;
			gi_q        <= '0;
			gj_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_D_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_FILL: begin
					n_q <= n_q + 8'd1;
					if (n_q == BOX_LAST) begin
						j_q   <= '0;
						pos_q <= '0;
						state_q <= sched_q ? S_K_RD_I : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						if (req_type == REQ_KEY) begin
							if (key_count_q < CW'(KEY_MAX)) begin
								key_count_q <= key_count_q + CW'(1);
							end
							if (key_last) begin
								sched_q <= 1'b1;
								n_q     <= '0;
								state_q <= S_FILL;
							end
						end else begin
							data_q  <= byte_value;
							gi_q    <= gi_q + 8'd1;
							state_q <= S_D_RD_I;
						end
					end
				end
				S_K_RD_I: begin
					state_q <= S_K_RD_J;
				end
				S_K_RD_J: begin
					si_q    <= box_rd_q;
					j_q     <= j_q + box_rd_q + kb;
					state_q <= S_K_WR_I;
				end
				S_K_WR_I: begin
					state_q <= S_K_WR_J;
				end
				S_K_WR_J: begin
					pos_q <= (pos_inc >= key_count_q) ? '0 : pos_inc[KW-1:0];
					n_q   <= n_q + 8'd1;
					if (n_q == BOX_LAST) begin
						gi_q        <= '0;
						gj_q        <= '0;
						key_count_q <= '0;
						sched_q     <= 1'b0;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_K_RD_I;
					end
				end
				S_D_RD_I: begin
					state_q <= S_D_RD_J;
				end
				S_D_RD_J: begin
					si_q    <= box_rd_q;
					gj_q    <= gj_q + box_rd_q;
					state_q <= S_D_WR_I;
				end
				S_D_WR_I: begin
					sj_q    <= box_rd_q;
					state_q <= S_D_WR_J;
				end
				S_D_WR_J: begin
					state_q <= S_D_RD_T;
				end
				S_D_RD_T: begin
					state_q <= S_D_OUT;
				end
				S_D_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_byte_q  <= data_q ^ box_rd_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a result only appears at the end of a data transaction
	a_out_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_D_OUT))
		else $error("output valid rose outside the data output step");

	// key store never overfills
	a_key_count: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= CW'(KEY_MAX))
		else $error("key count above key store depth");

	// schedule only walks held key bytes
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_K_RD_I) |-> (CW'(pos_q) < key_count_q))
		else $error("key position outside held key");

	// the first and last box steps of each schedule entry keep the schedule flag set
	a_sched_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_K_RD_I || state_q == S_K_WR_J) |-> sched_q)
		else $error("key schedule step without schedule flag");

endmodule
